// ===== rtl/brth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brth_pkg
// Shared types, constants and helper functions of the tap/hold button remapper.
// ----------------------------------------------------------------------------
package brth_pkg;

	localparam int SLOTS      = 8;
	localparam int NSRC       = 8;
	localparam int LIVE_SLOTS = (SLOTS < NSRC) ? SLOTS : NSRC;

	localparam int TIME_W     = 48;
	localparam int BTN_W      = 16;
	localparam int AN_W       = 8;
	localparam int MODE_W     = 2;
	localparam int CODE_W     = 5;
	localparam int HOLD_W     = 13;
	localparam int BIT_IDX_W  = 4;
	localparam int MAP_W      = NSRC * CODE_W;
	localparam int TRIG_W     = 4 * CODE_W;
	localparam int HOLD_REG_W = 4 * HOLD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = HOLD_REG_W;

	localparam logic [MAP_W-1:0]  PLAY_MAP_RST   = MAP_W'(64'd282739555853);
	localparam logic [MAP_W-1:0]  SCREEN_MAP_RST = MAP_W'(64'd282739555853);
	localparam logic [TRIG_W-1:0] TRIG_MAP_RST   = TRIG_W'(32'd607825);

	localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(5000);
	localparam logic [TIME_W:0]   TAP_MS   = (TIME_W + 1)'(120);
	localparam logic [AN_W-1:0]   AN_FULL  = '1;

	localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WHEEL  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCREEN = 2'd2;

	localparam logic [CODE_W-1:0] CODE_NONE  = 5'd0;
	localparam logic [CODE_W-1:0] CODE_LEFT  = 5'd17;
	localparam logic [CODE_W-1:0] CODE_RIGHT = 5'd18;

	localparam logic [BIT_IDX_W-1:0] LEFT_THUMB_BIT = 4'd6;

	localparam int TRIG_PLAY_L   = 0;
	localparam int TRIG_PLAY_R   = 1;
	localparam int TRIG_SCREEN_L = 2;
	localparam int TRIG_SCREEN_R = 3;

	localparam logic [BIT_IDX_W-1:0] SRC_BIT [NSRC] = '{
		4'd12, 4'd15, 4'd14, 4'd13, 4'd8, 4'd9, 4'd6, 4'd7
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLAY_MAP   = 3'd0,
		CFG_TAP_MAP    = 3'd1,
		CFG_SCREEN_MAP = 3'd2,
		CFG_TRIG_MAP   = 3'd3,
		CFG_HOLD_LOW   = 3'd4,
		CFG_HOLD_HIGH  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [BTN_W-1:0] btn;
		logic [AN_W-1:0]  lft;
		logic [AN_W-1:0]  rgt;
	} emit_t;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic              on;
		logic              screen;
		logic              wheel;
		logic              thumb;
		logic [HOLD_W-1:0] hold;
		logic [CODE_W-1:0] tap;
		logic [CODE_W-1:0] play;
		logic [CODE_W-1:0] scr;
	} lane_in_t;

	function automatic logic [BTN_W-1:0] owned_mask();
		logic [BTN_W-1:0] m;
		m = '0;
		for (int i = 0; i < LIVE_SLOTS; i++) begin
			m[SRC_BIT[i]] = 1'b1;
		end
		return m;
	endfunction

	function automatic emit_t emit_code(logic [CODE_W-1:0] code, logic pressed,
			logic [AN_W-1:0] analog);
		emit_t           e;
		logic [CODE_W-1:0] idx;
		e   = '0;
		idx = code - 5'd1;
		case (code) inside
			[5'd1:5'd16]: begin
				e.btn[idx[BIT_IDX_W-1:0]] = pressed;
			end
			CODE_LEFT: begin
				e.lft = analog;
			end
			CODE_RIGHT: begin
				e.rgt = analog;
			end
			default: begin
				e = '0;
			end
		endcase
		return e;
	endfunction

	function automatic emit_t emit_merge(emit_t a, emit_t b);
		emit_t r;
		r.btn = a.btn | b.btn;
		r.lft = (a.lft > b.lft) ? a.lft : b.lft;
		r.rgt = (a.rgt > b.rgt) ? a.rgt : b.rgt;
		return r;
	endfunction

endpackage

// ===== rtl/brth_poll_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brth_poll_if
// Input channel carrying one gamepad poll per item.
// ----------------------------------------------------------------------------
interface brth_poll_if;
	logic                           valid;
	logic                           ready;
	logic [brth_pkg::TIME_W-1:0]    now_ms;
	logic [brth_pkg::BTN_W-1:0]     buttons_in;
	logic [brth_pkg::AN_W-1:0]      left_in;
	logic [brth_pkg::AN_W-1:0]      right_in;
	logic [brth_pkg::MODE_W-1:0]    layout_mode;

	modport source (output valid, now_ms, buttons_in, left_in, right_in, layout_mode,
		input ready);
	modport sink (input valid, now_ms, buttons_in, left_in, right_in, layout_mode,
		output ready);
endinterface

// ===== rtl/brth_pad_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brth_pad_if
// Output channel carrying one remapped pad state per item.
// ----------------------------------------------------------------------------
interface brth_pad_if;
	logic                       valid;
	logic                       ready;
	logic [brth_pkg::BTN_W-1:0] buttons_out;
	logic [brth_pkg::AN_W-1:0]  left_out;
	logic [brth_pkg::AN_W-1:0]  right_out;

	modport source (output valid, buttons_out, left_out, right_out, input ready);
	modport sink (input valid, buttons_out, left_out, right_out, output ready);
endinterface

// ===== rtl/brth_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brth_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface brth_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [brth_pkg::CFG_IDX_W-1:0]  index;
	logic [brth_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/button_remap_tap_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_remap_tap_hold
// Remaps owned gamepad buttons and triggers through configurable target codes
// with per-slot hold delays and tap pulses, one lane per source slot.
//
//   Channel  Dir  Payload                                         Accepted when
//   poll     in   now_ms, buttons_in, left_in, right_in, mode     valid & ready
//   remap    out  buttons_out, left_out, right_out                valid & ready
//   cfg      in   index, data                                     valid & ready
//
// One poll is taken every cycle while the output is not stalled; its result is
// registered in the lane stage and then in the merge stage.
// Slot state is updated as the poll is accepted, so the next poll sees it.
// A stalled output holds the merge register; the lane stage still takes a
// poll while it is empty or moving on. The register port is always ready.
// Reset restores the register defaults and clears all slot state.
// ----------------------------------------------------------------------------
module button_remap_tap_hold (
	input  logic       clk,
	input  logic       arst_n,
	brth_poll_if.sink  poll,
	brth_pad_if.source remap,
	brth_cfg_if.sink   cfg
);

	logic [brth_pkg::MAP_W-1:0]        play_map_q;
	logic [brth_pkg::MAP_W-1:0]        tap_map_q;
	logic [brth_pkg::MAP_W-1:0]        screen_map_q;
	logic [brth_pkg::TRIG_W-1:0]       trig_map_q;
	logic [brth_pkg::HOLD_REG_W-1:0]   hold_low_q;
	logic [brth_pkg::HOLD_REG_W-1:0]   hold_high_q;
	logic [2*brth_pkg::HOLD_REG_W-1:0] hold_all;

	logic                              vld_s1;
	logic                              vld_s2;
	logic                              acc_in;
	logic                              adv2;
	logic                              screen;
	logic                              wheel;

	logic [brth_pkg::CODE_W-1:0]       tl_code;
	logic [brth_pkg::CODE_W-1:0]       tr_code;
	brth_pkg::emit_t                   trig_d;
	brth_pkg::emit_t                   trig_s1;
	logic [brth_pkg::BTN_W-1:0]        pass_s1;
	brth_pkg::emit_t                   lane_s1 [brth_pkg::LIVE_SLOTS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_map_q   <= brth_pkg::PLAY_MAP_RST;
			tap_map_q    <= '0;
			screen_map_q <= brth_pkg::SCREEN_MAP_RST;
			trig_map_q   <= brth_pkg::TRIG_MAP_RST;
			hold_low_q   <= '0;
			hold_high_q  <= '0;
		end else if (cfg.valid) begin
			case (brth_pkg::cfg_idx_t'(cfg.index))
				brth_pkg::CFG_PLAY_MAP:   play_map_q   <= cfg.data[brth_pkg::MAP_W-1:0];
				brth_pkg::CFG_TAP_MAP:    tap_map_q    <= cfg.data[brth_pkg::MAP_W-1:0];
				brth_pkg::CFG_SCREEN_MAP: screen_map_q <= cfg.data[brth_pkg::MAP_W-1:0];
				brth_pkg::CFG_TRIG_MAP:   trig_map_q   <= cfg.data[brth_pkg::TRIG_W-1:0];
				brth_pkg::CFG_HOLD_LOW:   hold_low_q   <= cfg.data;
				brth_pkg::CFG_HOLD_HIGH:  hold_high_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign hold_all    = {hold_high_q, hold_low_q};
	assign adv2        = vld_s1 && (!vld_s2 || remap.ready);
	assign poll.ready  = !vld_s1 || adv2;
	assign acc_in      = poll.valid && poll.ready;
	assign remap.valid = vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (poll.ready) begin
				vld_s1 <= poll.valid;
			end
			if (!vld_s2 || remap.ready) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_comb begin
		screen  = poll.layout_mode >= brth_pkg::MODE_SCREEN;
		wheel   = poll.layout_mode == brth_pkg::MODE_WHEEL;
		tl_code = screen ? trig_map_q[brth_pkg::CODE_W*brth_pkg::TRIG_SCREEN_L +: brth_pkg::CODE_W]
			: trig_map_q[brth_pkg::CODE_W*brth_pkg::TRIG_PLAY_L +: brth_pkg::CODE_W];
		tr_code = screen ? trig_map_q[brth_pkg::CODE_W*brth_pkg::TRIG_SCREEN_R +: brth_pkg::CODE_W]
			: trig_map_q[brth_pkg::CODE_W*brth_pkg::TRIG_PLAY_R +: brth_pkg::CODE_W];
		trig_d  = brth_pkg::emit_merge(
			brth_pkg::emit_code(tl_code, poll.left_in[brth_pkg::AN_W-1], poll.left_in),
			brth_pkg::emit_code(tr_code, poll.right_in[brth_pkg::AN_W-1], poll.right_in));
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			trig_s1 <= trig_d;
			pass_s1 <= poll.buttons_in & ~brth_pkg::owned_mask();
		end
	end

	for (genvar g = 0; g < brth_pkg::LIVE_SLOTS; g++) begin : g_lane
		brth_pkg::lane_in_t li;

		always_comb begin
			li.now    = poll.now_ms;
			li.on     = poll.buttons_in[brth_pkg::SRC_BIT[g]];
			li.screen = screen;
			li.wheel  = wheel;
			li.thumb  = brth_pkg::SRC_BIT[g] == brth_pkg::LEFT_THUMB_BIT;
			li.hold   = hold_all[brth_pkg::HOLD_W*g +: brth_pkg::HOLD_W];
			li.tap    = tap_map_q[brth_pkg::CODE_W*g +: brth_pkg::CODE_W];
			li.play   = play_map_q[brth_pkg::CODE_W*g +: brth_pkg::CODE_W];
			li.scr    = screen_map_q[brth_pkg::CODE_W*g +: brth_pkg::CODE_W];
		end

		brth_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ld     (acc_in),
			.li     (li),
			.res_s1 (lane_s1[g])
		);
	end

	brth_merge u_merge (
		.clk        (clk),
		.ld         (adv2),
		.lane_s1    (lane_s1),
		.trig_s1    (trig_s1),
		.pass_s1    (pass_s1),
		.buttons_s2 (remap.buttons_out),
		.left_s2    (remap.left_out),
		.right_s2   (remap.right_out)
	);

endmodule

// ===== rtl/brth_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brth_lane
// One source button slot: press tracking, hold suppression and tap pulse.
// ----------------------------------------------------------------------------
module brth_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ld,
	input  brth_pkg::lane_in_t li,
	output brth_pkg::emit_t    res_s1
);

	logic                            was_pressed_q;
	logic [brth_pkg::TIME_W-1:0]     press_time_q;
	logic [brth_pkg::TIME_W-1:0]     tap_end_q;

	logic                            wp_d;
	logic [brth_pkg::TIME_W-1:0]     pt_d;
	logic [brth_pkg::TIME_W-1:0]     te_d;
	brth_pkg::emit_t                 res_d;

	logic [brth_pkg::HOLD_W-1:0]     hold;
	logic                            start;
	logic [brth_pkg::TIME_W-1:0]     held;
	logic                            under;
	logic                            tap_ok;
	logic                            fire;
	logic [brth_pkg::TIME_W:0]       te_sum;
	logic [brth_pkg::TIME_W-1:0]     te_sat;
	logic [brth_pkg::TIME_W-1:0]     te_new;
	logic                            tap_on;
	logic                            play_on;
	brth_pkg::emit_t                 tap_e;
	brth_pkg::emit_t                 play_e;

	always_comb begin
		hold   = (li.hold > brth_pkg::HOLD_MAX) ? brth_pkg::HOLD_MAX : li.hold;
		start  = li.on && !was_pressed_q;
		held   = li.now - press_time_q;
		under  = start ? (hold != '0)
			: ((held[brth_pkg::TIME_W-1:brth_pkg::HOLD_W] == '0)
				&& (held[brth_pkg::HOLD_W-1:0] < hold));
		tap_ok = (li.tap != brth_pkg::CODE_NONE) && (li.tap <= brth_pkg::CODE_RIGHT);
		fire   = !li.on && was_pressed_q && tap_ok && under;
		te_sum = {1'b0, li.now} + brth_pkg::TAP_MS;
		te_sat = te_sum[brth_pkg::TIME_W] ? '1 : te_sum[brth_pkg::TIME_W-1:0];
		te_new = fire ? te_sat : tap_end_q;
		tap_on = li.now < te_new;
		play_on = li.on && !((hold != '0) && under);
		tap_e  = tap_on ? brth_pkg::emit_code(li.tap, 1'b1, brth_pkg::AN_FULL) : '0;
		play_e = brth_pkg::emit_code(li.play, play_on,
			play_on ? brth_pkg::AN_FULL : '0);

		if (li.screen) begin
			wp_d  = 1'b0;
			pt_d  = press_time_q;
			te_d  = '0;
			res_d = brth_pkg::emit_code(li.scr, li.on, li.on ? brth_pkg::AN_FULL : '0);
		end else if (li.wheel && li.thumb) begin
			wp_d  = li.on;
			pt_d  = press_time_q;
			te_d  = '0;
			res_d = brth_pkg::emit_code(
				brth_pkg::CODE_W'(brth_pkg::LEFT_THUMB_BIT) + 5'd1, li.on,
				li.on ? brth_pkg::AN_FULL : '0);
		end else begin
			wp_d  = li.on;
			pt_d  = start ? li.now : press_time_q;
			te_d  = te_new;
			res_d = brth_pkg::emit_merge(tap_e, play_e);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= 1'b0;
			press_time_q  <= '0;
			tap_end_q     <= '0;
		end else if (ld) begin
			was_pressed_q <= wp_d;
			press_time_q  <= pt_d;
			tap_end_q     <= te_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			res_s1 <= res_d;
		end
	end

endmodule

// ===== rtl/brth_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brth_merge
// Combines the lane results, the trigger result and the untouched button bits
// into the output register.
// ----------------------------------------------------------------------------
module brth_merge (
	input  logic                       clk,
	input  logic                       ld,
	input  brth_pkg::emit_t            lane_s1 [brth_pkg::LIVE_SLOTS],
	input  brth_pkg::emit_t            trig_s1,
	input  logic [brth_pkg::BTN_W-1:0] pass_s1,
	output logic [brth_pkg::BTN_W-1:0] buttons_s2,
	output logic [brth_pkg::AN_W-1:0]  left_s2,
	output logic [brth_pkg::AN_W-1:0]  right_s2
);

	brth_pkg::emit_t acc;

	always_comb begin
		acc = trig_s1;
		for (int i = 0; i < brth_pkg::LIVE_SLOTS; i++) begin
			acc = brth_pkg::emit_merge(acc, lane_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			buttons_s2 <= acc.btn | pass_s1;
			left_s2    <= acc.lft;
			right_s2   <= acc.rgt;
		end
	end

endmodule
